// File: hw/rtl/tpa_pkg.sv
// Shared types and constants for the triangle primitive assembler.
`timescale 1ns / 1ps

package tpa_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // register index within the CSR space (byte address = 4 * index)
   localparam logic CSR_IDX_PROJECTION = 1'b0;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_VERTEX = 2'd1,
      OP_END    = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_LIST  = 2'd0,
      MODE_STRIP = 2'd1,
      MODE_FAN   = 2'd2,
      MODE_OTHER = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PROJ_ABC = 2'd0,
      PROJ_CBA = 2'd1,
      PROJ_BCA = 2'd2
   } proj_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   typedef struct packed {
      vertex_type v1;
      vertex_type v2;
      vertex_type v3;
   } triangle_type;

   typedef struct packed {
      logic [1:0] opcode;
      mode_type   prim_mode;
      coord_type  coord_a;
      coord_type  coord_b;
      coord_type  coord_c;
   } request_type;

endpackage

// File: hw/rtl/tpa_csr.sv
// APB-style configuration register block holding the projection select.
`timescale 1ns / 1ps

module tpa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tpa_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tpa_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tpa_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output logic [1:0]                          projection
);

   logic       proj_sel;
   logic       proj_wr;
   logic [1:0] proj_ff;
   logic [1:0] proj_in;

   assign csr_pready = 1'b1;
   assign proj_sel   = (csr_paddr[tpa_pkg::CSR_ADDR_WIDTH-1] == tpa_pkg::CSR_IDX_PROJECTION);
   assign proj_wr    = csr_psel & csr_penable & csr_pwrite & csr_pready & proj_sel;

   always_comb begin
      proj_in = proj_ff;
      if (proj_wr) begin
         proj_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_ff <= tpa_pkg::PROJ_ABC;
      end else begin
         proj_ff <= proj_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (proj_sel) begin
         csr_prdata = {{(tpa_pkg::CSR_DATA_WIDTH-2){1'b0}}, proj_ff};
      end
   end

   assign projection = proj_ff;

endmodule

// File: hw/rtl/tpa_core.sv
// Vertex reorder, held-vertex state and triangle formation for list, strip and fan.
`timescale 1ns / 1ps

module tpa_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  tpa_pkg::request_type  req,
   input  logic [1:0]            projection,
   output logic                  emit,
   output tpa_pkg::triangle_type tri_out
);

   tpa_pkg::vertex_type held1_ff, held1_in;
   tpa_pkg::vertex_type held2_ff, held2_in;
   logic [1:0]          count_ff, count_in;
   tpa_pkg::mode_type   mode_ff, mode_in;
   logic                parity_ff, parity_in;
   tpa_pkg::vertex_type vtx;

   always_comb begin
      case (projection)
         tpa_pkg::PROJ_CBA: vtx = '{x: req.coord_c, y: req.coord_b, z: req.coord_a};
         tpa_pkg::PROJ_BCA: vtx = '{x: req.coord_b, y: req.coord_c, z: req.coord_a};
         default:           vtx = '{x: req.coord_a, y: req.coord_b, z: req.coord_c};
      endcase
   end

   always_comb begin
      held1_in   = held1_ff;
      held2_in   = held2_ff;
      count_in   = count_ff;
      mode_in    = mode_ff;
      parity_in  = parity_ff;
      emit       = 1'b0;
      tri_out.v1 = held1_ff;
      tri_out.v2 = held2_ff;
      tri_out.v3 = vtx;
      if (accept) begin
         case (req.opcode)
            tpa_pkg::OP_BEGIN: begin
               mode_in   = req.prim_mode;
               count_in  = 2'd0;
               parity_in = 1'b0;
            end
            tpa_pkg::OP_END: begin
               count_in  = 2'd0;
               parity_in = 1'b0;
            end
            tpa_pkg::OP_VERTEX: begin
               case (count_ff)
                  2'd0: begin
                     held1_in = vtx;
                     count_in = 2'd1;
                  end
                  2'd1: begin
                     held2_in = vtx;
                     count_in = 2'd2;
                  end
                  2'd2: begin
                     case (mode_ff)
                        tpa_pkg::MODE_LIST: begin
                           emit     = 1'b1;
                           count_in = 2'd0;
                        end
                        tpa_pkg::MODE_STRIP: begin
                           emit = 1'b1;
                           if (parity_ff) begin
                              tri_out.v1 = held2_ff;
                              tri_out.v2 = held1_ff;
                           end
                           held1_in  = held2_ff;
                           held2_in  = vtx;
                           parity_in = ~parity_ff;
                        end
                        tpa_pkg::MODE_FAN: begin
                           emit     = 1'b1;
                           held2_in = vtx;
                        end
                        default: begin
                           count_in = 2'd3;
                        end
                     endcase
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         mode_ff   <= tpa_pkg::MODE_LIST;
         parity_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         parity_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      held1_ff <= held1_in;
      held2_ff <= held2_in;
   end

   // a full count only arises in the no-output mode
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd3) |-> (mode_ff == tpa_pkg::MODE_OTHER))
      else $error("tpa_core: count saturated outside the no-output mode");

   assert property (@(posedge clock) disable iff (reset)
      parity_ff |-> (mode_ff == tpa_pkg::MODE_STRIP))
      else $error("tpa_core: strip parity set outside strip mode");

   assert property (@(posedge clock) disable iff (reset)
      emit |-> (count_ff == 2'd2 && req.opcode == tpa_pkg::OP_VERTEX))
      else $error("tpa_core: triangle emitted without two held vertices");

   assert property (@(posedge clock) disable iff (reset)
      (emit && mode_ff == tpa_pkg::MODE_STRIP) |=> (held1_ff == $past(held2_ff)))
      else $error("tpa_core: strip step did not shift the held vertices");

endmodule

// File: hw/rtl/tpa_rsp_reg.sv
// Result register for the triangle channel with its valid flag.
`timescale 1ns / 1ps

module tpa_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tpa_pkg::triangle_type tri_in,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  can_load,
   output tpa_pkg::triangle_type tri_out
);

   logic                  valid_ff, valid_in;
   tpa_pkg::triangle_type tri_ff, tri_next_in;

   assign can_load = ~valid_ff | rsp_ready;

   always_comb begin
      valid_in    = valid_ff & ~rsp_ready;
      tri_next_in = tri_ff;
      if (load) begin
         valid_in    = 1'b1;
         tri_next_in = tri_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tri_ff <= tri_next_in;
   end

   assign rsp_valid = valid_ff;
   assign tri_out   = tri_ff;

endmodule

// File: hw/rtl/triangle_primitive_assembler_top.sv
// Top level of the triangle primitive assembler.
`timescale 1ns / 1ps

// Takes one request per cycle (begin, vertex or end) and emits a triangle of nine
// coordinates in the cycle after the vertex that completes it. Vertices are reordered
// by the projection register, then assembled as a list, strip (alternating winding)
// or fan; the other mode emits nothing. A single result register sits on the
// output; req_ready drops only when that register is full and rsp_ready is low,
// so no request is taken while a triangle waits. Sustained rate is one request
// per cycle, set by the result register being drained every cycle.
module triangle_primitive_assembler_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [1:0]                          req_prim_mode,
   input  logic signed [tpa_pkg::COORD_WIDTH-1:0] req_coord_a,
   input  logic signed [tpa_pkg::COORD_WIDTH-1:0] req_coord_b,
   input  logic signed [tpa_pkg::COORD_WIDTH-1:0] req_coord_c,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v1_x,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v1_y,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v1_z,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v2_x,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v2_y,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v2_z,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v3_x,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v3_y,
   output logic signed [tpa_pkg::COORD_WIDTH-1:0] rsp_v3_z,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tpa_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tpa_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tpa_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   logic                  accept;
   logic                  emit;
   logic                  can_load;
   logic [1:0]            projection;
   tpa_pkg::request_type  req;
   tpa_pkg::triangle_type tri_core;
   tpa_pkg::triangle_type tri_rsp;

   assign req_ready = can_load;
   assign accept    = req_valid & req_ready;

   assign req.opcode    = req_opcode;
   assign req.prim_mode = tpa_pkg::mode_type'(req_prim_mode);
   assign req.coord_a   = req_coord_a;
   assign req.coord_b   = req_coord_b;
   assign req.coord_c   = req_coord_c;

   tpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .projection  (projection)
   );

   tpa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req),
      .projection (projection),
      .emit       (emit),
      .tri_out    (tri_core)
   );

   tpa_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .tri_in    (tri_core),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .tri_out   (tri_rsp)
   );

   assign rsp_v1_x = tri_rsp.v1.x;
   assign rsp_v1_y = tri_rsp.v1.y;
   assign rsp_v1_z = tri_rsp.v1.z;
   assign rsp_v2_x = tri_rsp.v2.x;
   assign rsp_v2_y = tri_rsp.v2.y;
   assign rsp_v2_z = tri_rsp.v2.z;
   assign rsp_v3_x = tri_rsp.v3.x;
   assign rsp_v3_y = tri_rsp.v3.y;
   assign rsp_v3_z = tri_rsp.v3.z;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the triangle primitive assembler top level.
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] PROJ_UNUSED = 2'd3;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam logic [31:0] PROJ_PLAN [8] = '{
      {30'h0, tpa_pkg::PROJ_CBA}, {30'h0, tpa_pkg::PROJ_BCA}, {30'h0, PROJ_UNUSED},
      {30'h0, tpa_pkg::PROJ_ABC}, {30'h0, tpa_pkg::PROJ_BCA}, {30'h0, tpa_pkg::PROJ_CBA},
      {30'h3FFF_FFFF, tpa_pkg::PROJ_ABC}, {30'h2000_0000, tpa_pkg::PROJ_BCA}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_opcode = '0;
   logic [1:0]           req_prim_mode = '0;
   tpa_pkg::coord_type   req_coord_a = '0;
   tpa_pkg::coord_type   req_coord_b = '0;
   tpa_pkg::coord_type   req_coord_c = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   tpa_pkg::coord_type   rsp_v1_x, rsp_v1_y, rsp_v1_z;
   tpa_pkg::coord_type   rsp_v2_x, rsp_v2_y, rsp_v2_z;
   tpa_pkg::coord_type   rsp_v3_x, rsp_v3_y, rsp_v3_z;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [tpa_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [tpa_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [tpa_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   triangle_primitive_assembler_top uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // assembler shadow state
   tpa_pkg::vertex_type  held1_q, held2_q;
   logic [1:0]           count_q;
   tpa_pkg::mode_type    mode_q;
   logic                 parity_q;
   logic [1:0]           proj_q;

   tpa_pkg::request_type  req_backlog [$];
   tpa_pkg::triangle_type triangles_due [$];
   tpa_pkg::request_type  cur_req;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  mismatches = 0;
   bit  hold_arm = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   string field_names [9] = '{"v1_x", "v1_y", "v1_z", "v2_x", "v2_y", "v2_z",
                              "v3_x", "v3_y", "v3_z"};

   function automatic bit assemble(input tpa_pkg::request_type rq,
                                   output tpa_pkg::triangle_type t);
      tpa_pkg::vertex_type v;
      t = '0;
      case (rq.opcode)
         tpa_pkg::OP_BEGIN: begin
            mode_q = rq.prim_mode;
            count_q = 2'd0;
            parity_q = 1'b0;
         end
         tpa_pkg::OP_END: begin
            count_q = 2'd0;
            parity_q = 1'b0;
         end
         tpa_pkg::OP_VERTEX: begin
            case (proj_q)
               tpa_pkg::PROJ_CBA: v = '{x: rq.coord_c, y: rq.coord_b, z: rq.coord_a};
               tpa_pkg::PROJ_BCA: v = '{x: rq.coord_b, y: rq.coord_c, z: rq.coord_a};
               default:           v = '{x: rq.coord_a, y: rq.coord_b, z: rq.coord_c};
            endcase
            case (count_q)
               2'd0: begin
                  held1_q = v;
                  count_q = 2'd1;
               end
               2'd1: begin
                  held2_q = v;
                  count_q = 2'd2;
               end
               2'd2: begin
                  case (mode_q)
                     tpa_pkg::MODE_LIST: begin
                        t = '{held1_q, held2_q, v};
                        count_q = 2'd0;
                        return 1'b1;
                     end
                     tpa_pkg::MODE_STRIP: begin
                        if (parity_q) t = '{held2_q, held1_q, v};
                        else t = '{held1_q, held2_q, v};
                        held1_q = held2_q;
                        held2_q = v;
                        parity_q = ~parity_q;
                        return 1'b1;
                     end
                     tpa_pkg::MODE_FAN: begin
                        t = '{held1_q, held2_q, v};
                        held2_q = v;
                        return 1'b1;
                     end
                     default: count_q = 2'd3;
                  endcase
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t: %s", $realtime, msg);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      tpa_pkg::triangle_type want;
      logic take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && req_ready;
         if (take && assemble(cur_req, want)) triangles_due.insert(triangles_due.size(), want);
         if (!req_valid || take) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = req_backlog.pop_front();
               req_opcode    <= cur_req.opcode;
               req_prim_mode <= cur_req.prim_mode;
               req_coord_a   <= cur_req.coord_a;
               req_coord_b   <= cur_req.coord_b;
               req_coord_c   <= cur_req.coord_c;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      tpa_pkg::triangle_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_v1_x, rsp_v1_y, rsp_v1_z, rsp_v2_x, rsp_v2_y, rsp_v2_z,
                   rsp_v3_x, rsp_v3_y, rsp_v3_z};
            if (triangles_due.size() == 0) begin
               note_mismatch($sformatf("unexpected triangle %h", got));
            end else begin
               want = triangles_due.pop_front();
               for (int k = 0; k < 9; k++)
                  if (got[287-32*k -: 32] !== want[287-32*k -: 32])
                     note_mismatch($sformatf("%s expected %h got %h", field_names[k],
                                             want[287-32*k -: 32], got[287-32*k -: 32]));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic tpa_pkg::coord_type rand_coord();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return -32'sd1;
         default: return tpa_pkg::coord_type'($urandom);
      endcase
   endfunction

   task automatic push_req(input logic [1:0] op, input logic [1:0] m,
                           input tpa_pkg::coord_type a, input tpa_pkg::coord_type b,
                           input tpa_pkg::coord_type c);
      tpa_pkg::request_type rq;
      rq.opcode = op;
      rq.prim_mode = tpa_pkg::mode_type'(m);
      rq.coord_a = a;
      rq.coord_b = b;
      rq.coord_c = c;
      req_backlog.insert(req_backlog.size(), rq);
   endtask

   task automatic push_vertex();
      push_req(tpa_pkg::OP_VERTEX, 2'($urandom), rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic push_marker(input logic [1:0] op, input logic [1:0] m);
      push_req(op, m, tpa_pkg::coord_type'($urandom), tpa_pkg::coord_type'($urandom),
               tpa_pkg::coord_type'($urandom));
   endtask

   task automatic build_random(input int n);
      int made;
      int nv;
      logic [1:0] op;
      made = 0;
      while (made < n) begin
         if ($urandom_range(99) < 85) begin
            push_marker(tpa_pkg::OP_BEGIN,
                        ($urandom_range(9) < 8) ? 2'($urandom_range(2)) : tpa_pkg::MODE_OTHER);
            nv = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(6, 1);
            repeat (nv) push_vertex();
            made += nv + 1;
            if ($urandom_range(3) != 0) begin
               push_marker(tpa_pkg::OP_END, 2'($urandom));
               made++;
            end
         end else begin
            repeat ($urandom_range(4, 1)) begin
               op = 2'($urandom);
               if (op == tpa_pkg::OP_VERTEX) push_vertex();
               else push_marker(op, 2'($urandom));
               if (op != OP_UNUSED) made++;
            end
         end
      end
   endtask

   task automatic drain();
      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (triangles_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apb_cycle(input logic wr, input logic [31:0] wdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {tpa_pkg::CSR_IDX_PROJECTION, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!wr && csr_prdata[1:0] !== proj_q)
         note_mismatch($sformatf("projection readback expected %0d got %0d",
                                 proj_q, csr_prdata[1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_projection(input logic [31:0] value);
      apb_cycle(1'b1, value);
      proj_q = value[1:0];
      apb_cycle(1'b0, '0);
   endtask

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      held1_q = '0;
      held2_q = '0;
      count_q = 2'd0;
      mode_q = tpa_pkg::MODE_LIST;
      parity_q = 1'b0;
      proj_q = tpa_pkg::PROJ_ABC;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: list from reset, ignored opcode, strip, fan, other, early end
      push_req(tpa_pkg::OP_VERTEX, tpa_pkg::MODE_LIST, 32'sh8000_0000, 32'sh7FFF_FFFF, '0);
      push_req(tpa_pkg::OP_VERTEX, tpa_pkg::MODE_OTHER, -32'sd1, '0, 32'sd1);
      push_req(tpa_pkg::OP_VERTEX, tpa_pkg::MODE_FAN, 32'sh7FFF_FFFF, 32'sh8000_0000,
               -32'sd1);
      push_req(OP_UNUSED, tpa_pkg::MODE_OTHER, -32'sd1, -32'sd1, -32'sd1);
      push_marker(tpa_pkg::OP_BEGIN, tpa_pkg::MODE_STRIP);
      repeat (4) push_vertex();
      push_marker(tpa_pkg::OP_BEGIN, tpa_pkg::MODE_FAN);
      repeat (4) push_vertex();
      push_marker(tpa_pkg::OP_BEGIN, tpa_pkg::MODE_OTHER);
      repeat (4) push_vertex();
      push_marker(tpa_pkg::OP_BEGIN, tpa_pkg::MODE_LIST);
      repeat (2) push_vertex();
      push_marker(tpa_pkg::OP_END, tpa_pkg::MODE_STRIP);
      repeat (3) push_vertex();
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         set_projection(PROJ_PLAN[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         if (ph == 0) hold_arm = 1'b1;
         build_random(ITEMS_PER_PHASE);
         drain();
      end

      repeat (16) @(posedge clock);
      if (mismatches == 0 && triangles_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/tpa_pkg.sv
hw/rtl/tpa_csr.sv
hw/rtl/tpa_core.sv
hw/rtl/tpa_rsp_reg.sv
hw/rtl/triangle_primitive_assembler_top.sv
dv/tb.sv
